[rtl/core/pcap_stream_deframer_assert.svh]
// Assertion macros for the pcap stream deframer.
// Needs aclk and aresetn in the scope of the module that expands them.
`ifndef PCAP_STREAM_DEFRAMER_ASSERT_SVH
`define PCAP_STREAM_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define PSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/psd_pkg.sv]
// Shared types, codes and byte-order helpers for the pcap stream deframer.
// No dependencies.
package psd_pkg;

    localparam logic [31:0] MAGIC_SWAPPED = 32'hd4c3b2a1;
    localparam logic [31:0] MAGIC_NATIVE  = 32'ha1b2c3d4;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PACKET_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MAJOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MINOR = 2'd2;

    localparam logic [31:0] PACKET_LIMIT_RESET   = 32'd0;
    localparam logic [15:0] EXPECTED_MAJOR_RESET = 16'd2;
    localparam logic [15:0] EXPECTED_MINOR_RESET = 16'd4;

    localparam logic [1:0] KIND_FILE_HEADER = 2'd0;
    localparam logic [1:0] KIND_RECORD      = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD     = 2'd2;
    localparam logic [1:0] KIND_ERROR       = 2'd3;

    localparam logic [1:0] ERR_BAD_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_BAD_VERSION = 2'd1;
    localparam logic [1:0] ERR_CAPTURE_LEN = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stop_request;
    } psd_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic [31:0] ts_seconds;
        logic [31:0] ts_micros;
        logic [31:0] captured_length;
        logic [31:0] original_length;
        logic [31:0] link_type;
        logic [31:0] snap_length;
        logic [1:0]  error_code;
    } psd_out_t;

    function automatic logic [31:0] rev32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Swap the bytes inside each 16-bit half.
    function automatic logic [31:0] rev16_pair(input logic [31:0] v);
        return {v[23:16], v[31:24], v[7:0], v[15:8]};
    endfunction

endpackage

[rtl/core/pcap_stream_deframer.sv]
// Top level of the pcap stream deframer: byte parser and two-entry result buffer.
// Depends on psd_pkg and pcap_stream_deframer_assert.svh.

// Takes a pcap capture file one byte per transaction and returns one result per
// file header, record header and payload byte, or an error. Every byte is parsed
// in the cycle it is accepted, so the block sustains one byte per clock; the
// limit is the result path, a main output register backed by one skid entry, and
// s_ready drops only while both hold a result. Byte order follows the magic word.
// After an error, a stop request or reaching packet_limit the block ignores all
// bytes until reset. Configuration registers: 0 packet_limit (0 is unlimited),
// 1 expected_major, 2 expected_minor; cfg_ready is always high.
`include "pcap_stream_deframer_assert.svh"

module pcap_stream_deframer
    import psd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  psd_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output psd_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [4:0] {
        PH_HDR     = 5'b00001,
        PH_HDR_BAD = 5'b00010,
        PH_REC     = 5'b00100,
        PH_PAY     = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    logic [31:0] packet_limit_reg;
    logic [15:0] expected_major_reg;
    logic [15:0] expected_minor_reg;

    phase_t      phase_reg, phase_next;
    logic [4:0]  byte_offset_reg, byte_offset_next;
    logic [31:0] field_shift_reg, field_shift_next;
    logic        order_swapped_reg, order_swapped_next;
    logic [31:0] file_snap_reg, file_snap_next;
    logic [31:0] file_link_reg, file_link_next;
    logic [31:0] file_version_reg, file_version_next;
    logic [31:0] rec_seconds_reg, rec_seconds_next;
    logic [31:0] rec_micros_reg, rec_micros_next;
    logic [31:0] rec_captured_reg, rec_captured_next;
    logic [31:0] rec_original_reg, rec_original_next;
    logic [31:0] payload_remaining_reg, payload_remaining_next;
    logic [31:0] packets_done_reg, packets_done_next;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    psd_out_t    main_data_reg;
    psd_out_t    skid_data_reg;

    logic        in_accept;
    logic        res_valid;
    psd_out_t    res;
    logic [31:0] word;
    logic [31:0] word_fixed;
    logic        word_end;
    logic [4:0]  offset_inc;
    logic        limit_hit;

    assign s_ready   = !skid_valid_reg;
    assign in_accept = s_valid && s_ready;
    assign m_valid   = main_valid_reg;
    assign m_data    = main_data_reg;
    assign cfg_ready = 1'b1;

    assign word       = {s_data.data_byte, field_shift_reg[31:8]};
    assign word_fixed = order_swapped_reg ? rev32(word) : word;
    assign word_end   = (byte_offset_reg[1:0] == 2'b11);
    assign offset_inc = byte_offset_reg + 5'd1;
    assign limit_hit  = (byte_offset_reg == 5'd0) && (packet_limit_reg != 32'd0) &&
                        (packets_done_reg >= packet_limit_reg);

    always_comb begin
        phase_next             = phase_reg;
        byte_offset_next       = byte_offset_reg;
        field_shift_next       = field_shift_reg;
        order_swapped_next     = order_swapped_reg;
        file_snap_next         = file_snap_reg;
        file_link_next         = file_link_reg;
        file_version_next      = file_version_reg;
        rec_seconds_next       = rec_seconds_reg;
        rec_micros_next        = rec_micros_reg;
        rec_captured_next      = rec_captured_reg;
        rec_original_next      = rec_original_reg;
        payload_remaining_next = payload_remaining_reg;
        packets_done_next      = packets_done_reg;
        res_valid              = 1'b0;
        res                    = '0;

        if (in_accept) begin
            if (s_data.stop_request) begin
                phase_next = PH_DONE;
            end else begin
                unique case (phase_reg)
                    PH_PAY: begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.payload_byte = s_data.data_byte;
                        if (payload_remaining_reg <= 32'd1) begin
                            res.last_byte          = 1'b1;
                            payload_remaining_next = '0;
                            if (packets_done_reg != '1) begin
                                packets_done_next = packets_done_reg + 32'd1;
                            end
                            phase_next       = PH_REC;
                            byte_offset_next = '0;
                        end else begin
                            payload_remaining_next = payload_remaining_reg - 32'd1;
                        end
                    end
                    PH_HDR, PH_HDR_BAD: begin
                        field_shift_next = word;
                        byte_offset_next = offset_inc;
                        if (word_end) begin
                            if (offset_inc == 5'd4) begin
                                // the magic itself sets the byte order
                                order_swapped_next = (word == MAGIC_SWAPPED);
                                if (word != MAGIC_SWAPPED && word != MAGIC_NATIVE) begin
                                    phase_next = PH_HDR_BAD;
                                end
                            end else if (offset_inc == 5'd8) begin
                                file_version_next = order_swapped_reg ? rev16_pair(word) : word;
                            end else if (offset_inc == 5'd20) begin
                                file_snap_next = word_fixed;
                            end else if (offset_inc == 5'd24) begin
                                file_link_next = word_fixed;
                            end
                        end
                        if (offset_inc >= 5'd24) begin
                            res_valid        = 1'b1;
                            byte_offset_next = '0;
                            if (phase_reg == PH_HDR_BAD) begin
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_BAD_MAGIC;
                                phase_next     = PH_DONE;
                            end else if (file_version_reg[15:0] != expected_major_reg ||
                                         file_version_reg[31:16] != expected_minor_reg) begin
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_BAD_VERSION;
                                phase_next     = PH_DONE;
                            end else begin
                                res.kind        = KIND_FILE_HEADER;
                                res.link_type   = word_fixed;
                                res.snap_length = file_snap_reg;
                                phase_next      = PH_REC;
                            end
                        end
                    end
                    PH_REC: begin
                        if (limit_hit) begin
                            phase_next = PH_DONE;
                        end else begin
                            field_shift_next = word;
                            byte_offset_next = offset_inc;
                            if (word_end) begin
                                if (offset_inc == 5'd4) begin
                                    rec_seconds_next = word_fixed;
                                end else if (offset_inc == 5'd8) begin
                                    rec_micros_next = word_fixed;
                                end else if (offset_inc == 5'd12) begin
                                    rec_captured_next = word_fixed;
                                end else if (offset_inc == 5'd16) begin
                                    rec_original_next = word_fixed;
                                end
                            end
                            if (offset_inc >= 5'd16) begin
                                res_valid        = 1'b1;
                                byte_offset_next = '0;
                                if (rec_captured_reg > file_snap_reg) begin
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_CAPTURE_LEN;
                                    phase_next     = PH_DONE;
                                end else begin
                                    res.kind            = KIND_RECORD;
                                    res.ts_seconds      = rec_seconds_reg;
                                    res.ts_micros       = rec_micros_reg;
                                    res.captured_length = rec_captured_reg;
                                    res.original_length = word_fixed;
                                    if (rec_captured_reg == 32'd0) begin
                                        // empty packet passes at once
                                        if (packets_done_reg != '1) begin
                                            packets_done_next = packets_done_reg + 32'd1;
                                        end
                                        phase_next = PH_REC;
                                    end else begin
                                        payload_remaining_next = rec_captured_reg;
                                        phase_next             = PH_PAY;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            packet_limit_reg   <= PACKET_LIMIT_RESET;
            expected_major_reg <= EXPECTED_MAJOR_RESET;
            expected_minor_reg <= EXPECTED_MINOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PACKET_LIMIT:   packet_limit_reg   <= cfg_data;
                CFG_EXPECTED_MAJOR: expected_major_reg <= cfg_data[15:0];
                CFG_EXPECTED_MINOR: expected_minor_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= PH_HDR;
            byte_offset_reg       <= '0;
            field_shift_reg       <= '0;
            order_swapped_reg     <= 1'b0;
            file_snap_reg         <= '0;
            file_link_reg         <= '0;
            file_version_reg      <= '0;
            rec_seconds_reg       <= '0;
            rec_micros_reg        <= '0;
            rec_captured_reg      <= '0;
            rec_original_reg      <= '0;
            payload_remaining_reg <= '0;
            packets_done_reg      <= '0;
        end else begin
            phase_reg             <= phase_next;
            byte_offset_reg       <= byte_offset_next;
            field_shift_reg       <= field_shift_next;
            order_swapped_reg     <= order_swapped_next;
            file_snap_reg         <= file_snap_next;
            file_link_reg         <= file_link_next;
            file_version_reg      <= file_version_next;
            rec_seconds_reg       <= rec_seconds_next;
            rec_micros_reg        <= rec_micros_next;
            rec_captured_reg      <= rec_captured_next;
            rec_original_reg      <= rec_original_next;
            payload_remaining_reg <= payload_remaining_next;
            packets_done_reg      <= packets_done_next;
        end
    end

    // Result buffer: main register drives the port, skid catches a result
    // produced while the main one is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (res_valid && (!main_valid_reg || m_ready)) begin
                main_valid_reg <= 1'b1;
            end else if (main_valid_reg && m_ready) begin
                main_valid_reg <= skid_valid_reg;
            end
            if (res_valid && main_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else if (main_valid_reg && m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && (!main_valid_reg || m_ready)) begin
            main_data_reg <= res;
        end else if (main_valid_reg && m_ready && skid_valid_reg) begin
            main_data_reg <= skid_data_reg;
        end
        if (res_valid && main_valid_reg && !m_ready) begin
            skid_data_reg <= res;
        end
    end

    `PSD_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid holds a result while main is empty")
    `PSD_ASSERT_NEXT(a_halt_sticky, phase_reg == PH_DONE, phase_reg == PH_DONE, "block left the halted phase")
    `PSD_ASSERT_NOW(a_payload_count, phase_reg == PH_PAY, payload_remaining_reg != 32'd0, "payload phase with no bytes left")
    `PSD_ASSERT_NEXT(a_error_halts, res_valid && res.kind == KIND_ERROR, phase_reg == PH_DONE, "error result without halting")

endmodule
